@@ sv/upd_pkg.sv @@
// Shared types, character codes and hex classification for the URL percent decoder.
package upd_pkg;

    // Character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

    // Escape phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Front-to-back queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified request
    typedef struct packed {
        logic [7:0] raw;
        logic       is_pct;
        logic       is_hex;
        logic [3:0] nib;
        logic       eom;
    } upd_tok_t;

    // Queue status seen by the back end and the top level
    typedef struct packed {
        logic valid;
    } upd_qstat_t;

    // Hex digit value; top bit flags a legal digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        logic       ok;
        v  = 8'd0;
        ok = 1'b0;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9) begin
            v  = c - CH_DIGIT0;
            ok = 1'b1;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            v  = c - CH_UPPER_A + HEX_LETTER_BASE;
            ok = 1'b1;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            v  = c - CH_LOWER_A + HEX_LETTER_BASE;
            ok = 1'b1;
        end
        return {ok, v[3:0]};
    endfunction

endpackage

@@ sv/upd_if.sv @@
// Stream interfaces: encoded bytes in, decoded results out.
interface upd_enc_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface upd_dec_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       bad_input;
    logic       message_done;

    modport source (output valid, output out_byte, output has_byte, output bad_input,
                    output message_done, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input bad_input,
                    input message_done, output ready);
endinterface

@@ sv/url_percent_decoder_core.sv @@
// Top level of the streaming URL percent decoder.
//
//   channel | dir | request payload
//   --------+-----+--------------------------------------------------
//   enc     | in  | in_byte[7:0], end_of_message
//   dec     | out | out_byte[7:0], has_byte, bad_input, message_done
//
// One byte per cycle while the output is not stalled; an accepted byte is
// written into the two-entry queue, then the phase machine loads the result
// register from the queue head. enc.ready depends only on queue fill,
// so an output stall backs up through the queue. Reset clears queue pointers,
// phase state and the result valid; no clearing pass is needed.
module url_percent_decoder_core (
    input  logic      clk,
    input  logic      rst_n,
    upd_enc_if.sink   enc,
    upd_dec_if.source dec
);
    import upd_pkg::*;

    upd_tok_t   q_tok;
    upd_qstat_t q_stat;
    logic       q_pop;

    upd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .enc    (enc),
        .q_pop  (q_pop),
        .q_tok  (q_tok),
        .q_stat (q_stat)
    );

    upd_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_tok  (q_tok),
        .q_stat (q_stat),
        .q_pop  (q_pop),
        .dec    (dec)
    );

    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("queue popped while empty");

    // A push without a pop leaves something queued
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (enc.valid && enc.ready && !q_pop) |=> q_stat.valid)
        else $error("accepted byte lost from queue");

    // An error result closes the message and carries no byte
    a_bad_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (dec.valid && dec.bad_input) |-> (dec.message_done && !dec.has_byte))
        else $error("error result malformed");

    // Every result carries a byte or closes a message
    a_result_meaningful: assert property (@(posedge clk) disable iff (!rst_n)
        dec.valid |-> (dec.has_byte || dec.message_done))
        else $error("empty result emitted");

endmodule

@@ sv/upd_front.sv @@
// Front end: accepts encoded bytes, classifies them and queues them for the back end.
module upd_front (
    input  logic              clk,
    input  logic              rst_n,
    upd_enc_if.sink           enc,
    input  logic              q_pop,
    output upd_pkg::upd_tok_t q_tok,
    output upd_pkg::upd_qstat_t q_stat
);
    import upd_pkg::*;

    upd_tok_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic                push;
    logic [4:0]          hex;
    upd_tok_t            tok_in;

    // Classify the incoming byte
    always_comb
    begin
        hex           = hex_decode(enc.in_byte);
        tok_in.raw    = enc.in_byte;
        tok_in.is_pct = (enc.in_byte == CH_PERCENT);
        tok_in.is_hex = hex[4];
        tok_in.nib    = hex[3:0];
        tok_in.eom    = enc.end_of_message;
    end

    assign enc.ready    = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push         = enc.valid && enc.ready;
    assign q_stat.valid = (count_reg != '0);
    assign q_tok        = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push  ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = QCNT_W'(count_reg + QCNT_W'(push) - QCNT_W'(q_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= tok_in;
        end
    end

endmodule

@@ sv/upd_back.sv @@
// Back end: escape phase machine and registered result stage.
module upd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  upd_pkg::upd_tok_t   q_tok,
    input  upd_pkg::upd_qstat_t q_stat,
    output logic                q_pop,
    upd_dec_if.source           dec
);
    import upd_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] hi_reg,    hi_next;
    logic       err_reg,   err_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic       has_reg, bad_reg, done_reg;

    logic       emit, fall;
    logic [7:0] r_byte;
    logic       r_has, r_bad, r_done;

    // Pop when the result register is free or draining this cycle
    assign q_pop = q_stat.valid && (!out_valid_reg || dec.ready);

    // Phase machine for one queued byte
    always_comb
    begin
        phase_next = phase_reg;
        hi_next    = hi_reg;
        err_next   = err_reg;
        emit       = 1'b0;
        fall       = 1'b1;
        r_byte     = 8'd0;
        r_has      = 1'b0;
        r_bad      = 1'b0;
        r_done     = 1'b0;
        if (!err_reg)
        begin
            unique case (phase_reg)
                PH_HIGH:
                begin
                    phase_next = q_tok.is_hex ? PH_LOW : PH_IDLE;
                    if (q_tok.is_hex)
                        hi_next = q_tok.nib;
                    else
                        err_next = 1'b1;
                end
                PH_LOW:
                begin
                    phase_next = PH_IDLE;
                    if (q_tok.is_hex)
                    begin
                        fall    = 1'b0;
                        emit    = 1'b1;
                        r_byte  = {hi_reg, q_tok.nib};
                        r_has   = 1'b1;
                        r_done  = q_tok.eom;
                        hi_next = 4'd0;
                    end
                    else
                        err_next = 1'b1;
                end
                // idle, and the unreachable fourth code
                default:
                begin
                    if (q_tok.is_pct)
                        phase_next = PH_HIGH;
                    else
                    begin
                        phase_next = PH_IDLE;
                        fall       = 1'b0;
                        emit       = 1'b1;
                        r_byte     = q_tok.raw;
                        r_has      = 1'b1;
                        r_done     = q_tok.eom;
                        if (q_tok.eom)
                            hi_next = 4'd0;
                    end
                end
            endcase
        end
        // Closing a bad or truncated message
        if (fall && q_tok.eom)
        begin
            emit   = 1'b1;
            r_byte = 8'd0;
            r_has  = 1'b0;
            r_bad  = 1'b1;
            r_done = 1'b1;
        end
        if (q_tok.eom)
        begin
            phase_next = PH_IDLE;
            hi_next    = 4'd0;
            err_next   = 1'b0;
        end
    end

    // Result register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !dec.ready;
        if (q_pop && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hi_reg        <= 4'd0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                phase_reg <= phase_next;
                hi_reg    <= hi_next;
                err_reg   <= err_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_byte_reg <= r_byte;
            has_reg      <= r_has;
            bad_reg      <= r_bad;
            done_reg     <= r_done;
        end
    end

    assign dec.valid        = out_valid_reg;
    assign dec.out_byte     = out_byte_reg;
    assign dec.has_byte     = has_reg;
    assign dec.bad_input    = bad_reg;
    assign dec.message_done = done_reg;

endmodule
